[hdl/mineig_pkg.sv]
// Shared types and constants for the 2x2 symmetric minimum eigenvalue block.
// Used by mineig_front, mineig_sqrt_cell and min_eigenvalue_2x2_sym.
`default_nettype none

package mineig_pkg;

	localparam int IN_WIDTH = 32;
	localparam int SUM_W    = IN_WIDTH + 1;
	localparam int MAG_W    = IN_WIDTH;
	localparam int PROD_W   = 2 * MAG_W;
	localparam int RAD_W    = 2 * IN_WIDTH + 2;
	localparam int ROOT_W   = RAD_W / 2;
	localparam int REM_W    = ROOT_W + 2;
	localparam int OUT_W    = SUM_W + 1;
	localparam int FRONT_STAGES = 4;
	localparam int LATENCY  = FRONT_STAGES + ROOT_W + 1;

	// One beat moving down the square root cell chain.
	typedef struct packed {
		logic                    valid;
		logic [REM_W-1:0]        rem;
		logic [ROOT_W-1:0]       root;
		logic [RAD_W-1:0]        rad;
		logic signed [SUM_W-1:0] sum;
		logic                    frame_end;
	} sq_beat_t;

endpackage

`default_nettype wire

[hdl/mineig_front.sv]
// Front pipeline: trace, |xx-yy|, |xy|, squares and the radicand.
// Depends on mineig_pkg; feeds the first mineig_sqrt_cell.
`default_nettype none

module mineig_front (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	input  wire logic signed [mineig_pkg::IN_WIDTH-1:0]   cov_xx,
	input  wire logic signed [mineig_pkg::IN_WIDTH-1:0]   cov_xy,
	input  wire logic signed [mineig_pkg::IN_WIDTH-1:0]   cov_yy,
	input  wire logic                                     frame_end,
	output mineig_pkg::sq_beat_t                          beat_out
);
	import mineig_pkg::*;

	logic [FRONT_STAGES-1:0] valid_q;

	logic signed [SUM_W-1:0] sum_s1, sum_s2, sum_s3, sum_s4;
	logic signed [SUM_W-1:0] dif_s1;
	logic signed [IN_WIDTH-1:0] xy_s1;
	logic [MAG_W-1:0] ad_s2, axy_s2;
	logic [PROD_W-1:0] d2_s3, q_s3;
	logic [RAD_W-1:0] rad_s4;
	logic [FRONT_STAGES-1:0] fe_q;

	logic [SUM_W-1:0] dif_neg;
	logic [IN_WIDTH-1:0] xy_neg;

	assign dif_neg = SUM_W'(-dif_s1);
	assign xy_neg  = IN_WIDTH'(-xy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[FRONT_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		fe_q   <= {fe_q[FRONT_STAGES-2:0], frame_end};
		sum_s1 <= SUM_W'(cov_xx) + SUM_W'(cov_yy);
		dif_s1 <= SUM_W'(cov_xx) - SUM_W'(cov_yy);
		xy_s1  <= cov_xy;
		// |xx-yy| < 2^32 and |xy| <= 2^31 both fit unsigned in MAG_W bits
		sum_s2 <= sum_s1;
		ad_s2  <= dif_s1[SUM_W-1] ? dif_neg[MAG_W-1:0] : dif_s1[MAG_W-1:0];
		axy_s2 <= xy_s1[IN_WIDTH-1] ? xy_neg : xy_s1;
		sum_s3 <= sum_s2;
		d2_s3  <= ad_s2 * ad_s2;
		q_s3   <= axy_s2 * axy_s2;
		sum_s4 <= sum_s3;
		rad_s4 <= RAD_W'(d2_s3) + {q_s3, 2'b00};
	end

	always_comb begin
		beat_out.valid     = valid_q[FRONT_STAGES-1];
		beat_out.rem       = '0;
		beat_out.root      = '0;
		beat_out.rad       = rad_s4;
		beat_out.sum       = sum_s4;
		beat_out.frame_end = fe_q[FRONT_STAGES-1];
	end

endmodule

`default_nettype wire

[hdl/mineig_sqrt_cell.sv]
// One digit of the restoring square root: takes two radicand bits, settles one root bit.
// Depends on mineig_pkg; instanced ROOT_W times in a chain by the top level.
`default_nettype none

module mineig_sqrt_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mineig_pkg::sq_beat_t beat_in,
	output mineig_pkg::sq_beat_t      beat_out
);
	import mineig_pkg::*;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic [REM_W:0]   diff;

	logic                    valid_q;
	logic [REM_W-1:0]        rem_q;
	logic [ROOT_W-1:0]       root_q;
	logic [RAD_W-1:0]        rad_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    fe_q;

	// bring down the next two radicand bits, try root*4+1
	assign rem_sh = {beat_in.rem[REM_W-3:0], beat_in.rad[RAD_W-1 -: 2]};
	assign trial  = {beat_in.root, 2'b01};
	assign diff   = {1'b0, rem_sh} - {1'b0, trial};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		rad_q <= {beat_in.rad[RAD_W-3:0], 2'b00};
		sum_q <= beat_in.sum;
		fe_q  <= beat_in.frame_end;
		if (!diff[REM_W]) begin
			rem_q  <= diff[REM_W-1:0];
			root_q <= {beat_in.root[ROOT_W-2:0], 1'b1};
		end else begin
			rem_q  <= rem_sh;
			root_q <= {beat_in.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_comb begin
		beat_out.valid     = valid_q;
		beat_out.rem       = rem_q;
		beat_out.root      = root_q;
		beat_out.rad       = rad_q;
		beat_out.sum       = sum_q;
		beat_out.frame_end = fe_q;
	end

	// remainder never exceeds twice the partial root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ({1'b0, rem_q} <= {2'b00, root_q, 1'b0}))
		else $error("sqrt cell remainder out of range");

endmodule

`default_nettype wire

[hdl/min_eigenvalue_2x2_sym.sv]
// Top level: smaller eigenvalue of a symmetric 2x2 matrix (Shi-Tomasi measure).
// Depends on mineig_pkg, mineig_front and mineig_sqrt_cell.
//
// Usage:
//   Drive cov_xx, cov_xy, cov_yy (signed Q16.16) and frame_end with start high
//   for one cycle; the beat is taken when start is high and busy is low. busy
//   is always low, so a new pixel may be given on every clock.
//   After a pixel is taken, done is high for one cycle with min_eigen (signed
//   Q18.16, 34 bits) and frame_end_out. Throughput is one pixel per cycle.
//   The pipeline is made of 4 front stages (sum, absolute values, two 32x32
//   squares, radicand add), one cell per root bit in the square root chain
//   (33 cells) and the output register.
//   Results come out in input order. The receiver cannot stall; done is a
//   one-cycle strobe that must be taken when it appears.
//   arst_n low clears every valid flag at once, dropping any pixels in flight;
//   the block takes pixels in the first cycle after reset is released.
`default_nettype none

module min_eigenvalue_2x2_sym (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     start,
	output wire logic                                     busy,
	input  wire logic signed [mineig_pkg::IN_WIDTH-1:0]   cov_xx,
	input  wire logic signed [mineig_pkg::IN_WIDTH-1:0]   cov_xy,
	input  wire logic signed [mineig_pkg::IN_WIDTH-1:0]   cov_yy,
	input  wire logic                                     frame_end,
	output logic                                          done,
	output logic signed [mineig_pkg::OUT_W-1:0]           min_eigen,
	output logic                                          frame_end_out
);
	import mineig_pkg::*;

	sq_beat_t chain [0:ROOT_W];

	logic signed [OUT_W:0] twice;

	assign busy = 1'b0;

	mineig_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.cov_xx   (cov_xx),
		.cov_xy   (cov_xy),
		.cov_yy   (cov_yy),
		.frame_end(frame_end),
		.beat_out (chain[0])
	);

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		mineig_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.beat_in (chain[i]),
			.beat_out(chain[i+1])
		);
	end

	// twice the eigenvalue, then drop the low bit for an arithmetic halve
	assign twice = (OUT_W+1)'(chain[ROOT_W].sum) - (OUT_W+1)'({1'b0, chain[ROOT_W].root});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= chain[ROOT_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		min_eigen     <= twice[OUT_W:1];
		frame_end_out <= chain[ROOT_W].frame_end;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result strobe missing after fixed latency");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY (frame_end_out == $past(frame_end, LATENCY)))
		else $error("frame end flag out of step with its pixel");

	// radicand stays below 2^65, so the root stays below 1.5 * 2^32
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chain[ROOT_W].valid |-> !(chain[ROOT_W].root[ROOT_W-1] && chain[ROOT_W].root[ROOT_W-2]))
		else $error("square root exceeds radicand range");

endmodule

`default_nettype wire
